### hw/rtl/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared constants for the vertex transform and perspective divide unit.
// ----------------------------------------------------------------------------
package vtpd_pkg;

  localparam int unsigned CoeffFracBits = 12;
  localparam int unsigned CoordFracBits = 16;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned CoeffW   = 16;
  localparam int unsigned RowW     = 4 * CoeffW;
  localparam int unsigned NumRows  = 4;
  localparam int unsigned RowIdxW  = $clog2(NumRows);

  localparam int unsigned ProdW    = CoeffW + CoordW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned ShiftW   = SumW - CoeffFracBits;

  localparam int unsigned NumW      = CoordW + CoordFracBits;
  localparam int unsigned DivStages = (NumW + 1) / 2;
  localparam int unsigned NumPadW   = 2 * DivStages;
  localparam int unsigned DenW      = CoordW - 1;

  localparam int unsigned PipeDepth = DivStages + 4;

endpackage

### hw/rtl/vtpd_in_if.sv
// ----------------------------------------------------------------------------
// vtpd_in_if
// Vertex input channel: valid/ready with four Q16.16 components.
// ----------------------------------------------------------------------------
interface vtpd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic signed [31:0] in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                  output ready);
endinterface

### hw/rtl/vtpd_out_if.sv
// ----------------------------------------------------------------------------
// vtpd_out_if
// Result channel: valid/ready with transformed vertex and status flags.
// ----------------------------------------------------------------------------
interface vtpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               was_divided;
  logic               saturated;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  output was_divided, output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  input was_divided, input saturated, output ready);
endinterface

### hw/rtl/vertex_transform_perspective_divide_unit.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_unit
// 4x4 fixed-point matrix transform of a vertex with perspective divide by w.
// Q16.16 path registers: products, clipped sums, divider stages, quotient.
// Throughput: one vertex per cycle; the whole pipeline holds on output stall.
// Depth is set by the two-bit-per-stage divider over the 48-bit numerator.
// Reset clears the valid bits and the coefficient rows to zero.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide_unit import vtpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  vtpd_in_if.sink            in_i,
  vtpd_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [RowIdxW-1:0] cfg_idx_i,
  input  logic [RowW-1:0]    cfg_data_i
);

  logic [RowW-1:0] row_q [NumRows];
  logic [PipeDepth-1:0] vld_q;
  logic adv;

  assign adv        = !vld_q[PipeDepth-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) row_q[r] <= '0;
    end else if (cfg_we_i) begin
      row_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_i.valid};
    end
  end

  // stage 1: products
  logic signed [CoordW-1:0] vin [4];
  logic signed [ProdW-1:0]  prod_q [NumRows][4];

  assign vin[0] = in_i.in_x;
  assign vin[1] = in_i.in_y;
  assign vin[2] = in_i.in_z;
  assign vin[3] = in_i.in_w;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < NumRows; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[r][c] <= ProdW'($signed(row_q[r][CoeffW*c +: CoeffW]) * vin[c]);
        end
      end
    end
  end

  // stage 2: sum, round, clip
  localparam logic signed [SumW-1:0]   RoundC = SumW'(1) <<< (CoeffFracBits - 1);
  localparam logic signed [ShiftW-1:0] MaxS   = ShiftW'({1'b0, {(CoordW-1){1'b1}}});
  localparam logic signed [ShiftW-1:0] MinS   = -MaxS - ShiftW'(1);

  logic signed [CoordW-1:0] t_d [NumRows];
  logic [NumRows-1:0]       tsat_d;
  logic signed [CoordW-1:0] t_q [NumRows];
  logic                     ssat_q;

  always_comb begin
    logic signed [SumW-1:0]   s;
    logic signed [ShiftW-1:0] sh;
    for (int r = 0; r < NumRows; r++) begin
      s = RoundC;
      for (int c = 0; c < 4; c++) s = s + SumW'(prod_q[r][c]);
      sh = ShiftW'(s >>> CoeffFracBits);
      tsat_d[r] = (sh > MaxS) || (sh < MinS);
      if (sh > MaxS)      t_d[r] = MaxS[CoordW-1:0];
      else if (sh < MinS) t_d[r] = MinS[CoordW-1:0];
      else                t_d[r] = sh[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q    <= t_d;
      ssat_q <= |tsat_d;
    end
  end

  // divide lanes and aligned side data
  logic signed [CoordW-1:0] q [3];
  logic [2:0]               qsat;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    vtpd_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .t_i   (t_q[l]),
      .den_i (t_q[3][DenW-1:0]),
      .q_o   (q[l]),
      .sat_o (qsat[l])
    );
  end

  localparam int unsigned DlyLen = DivStages + 2;

  logic signed [CoordW-1:0] dt_q   [DlyLen][NumRows];
  logic                     ddiv_q [DlyLen];
  logic                     dsat_q [DlyLen];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dt_q[0]   <= t_q;
      ddiv_q[0] <= t_q[3] > 0;
      dsat_q[0] <= ssat_q;
      for (int k = 1; k < DlyLen; k++) begin
        dt_q[k]   <= dt_q[k-1];
        ddiv_q[k] <= ddiv_q[k-1];
        dsat_q[k] <= dsat_q[k-1];
      end
    end
  end

  logic dv;
  assign dv = ddiv_q[DlyLen-1];

  assign out_o.valid       = vld_q[PipeDepth-1];
  assign out_o.out_x       = dv ? q[0] : dt_q[DlyLen-1][0];
  assign out_o.out_y       = dv ? q[1] : dt_q[DlyLen-1][1];
  assign out_o.out_z       = dv ? q[2] : dt_q[DlyLen-1][2];
  assign out_o.out_w       = dt_q[DlyLen-1][3];
  assign out_o.was_divided = dv;
  assign out_o.saturated   = dsat_q[DlyLen-1] || (dv && (|qsat));

  a_div_wpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.was_divided |-> out_o.out_w > 0)
    else $error("divided result with nonpositive w");

  a_nodiv_wneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.was_divided |-> out_o.out_w <= 0)
    else $error("undivided result with positive w");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output");

endmodule

### hw/rtl/vtpd_div.sv
// ----------------------------------------------------------------------------
// vtpd_div
// Pipelined restoring divider: (t << frac) / den, truncated and saturated.
// Two quotient bits per stage.
// ----------------------------------------------------------------------------
module vtpd_div import vtpd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CoordW-1:0] t_i,
  input  logic        [DenW-1:0]   den_i,
  output logic signed [CoordW-1:0] q_o,
  output logic                     sat_o
);

  logic [NumPadW-1:0] num_q [DivStages+1];
  logic [DenW-1:0]    rem_q [DivStages+1];
  logic [DenW-1:0]    den_q [DivStages+1];
  logic               neg_q [DivStages+1];

  logic [CoordW:0]    t_ext;
  logic [CoordW:0]    t_mag;
  logic [NumPadW-1:0] num0_d;

  logic signed [CoordW-1:0] q_q;
  logic                     sat_q;

  assign t_ext  = {t_i[CoordW-1], t_i};
  assign t_mag  = t_i[CoordW-1] ? (~t_ext + 1'b1) : t_ext;
  assign num0_d = NumPadW'(t_mag) << CoordFracBits;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= num0_d;
      rem_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= t_i[CoordW-1];
    end
  end

  for (genvar k = 1; k <= DivStages; k++) begin : g_stage
    logic [NumPadW-1:0] num_d;
    logic [DenW-1:0]    rem_d;

    always_comb begin
      logic [DenW:0]      r;
      logic [NumPadW-1:0] n;
      logic [DenW-1:0]    rm;
      n  = num_q[k-1];
      rm = rem_q[k-1];
      for (int i = 0; i < 2; i++) begin
        r = {rm, n[NumPadW-1]};
        n = n << 1;
        if (r >= {1'b0, den_q[k-1]}) begin
          r    = r - {1'b0, den_q[k-1]};
          n[0] = 1'b1;
        end
        rm = r[DenW-1:0];
      end
      num_d = n;
      rem_d = rm;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_d;
        rem_q[k] <= rem_d;
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  localparam logic [NumPadW-1:0] PosLim = NumPadW'({1'b0, {(CoordW-1){1'b1}}});
  localparam logic [NumPadW-1:0] NegLim = NumPadW'({1'b1, {(CoordW-1){1'b0}}});

  logic [NumPadW-1:0]       qm;
  logic signed [CoordW-1:0] q_d;
  logic                     sat_d;

  always_comb begin
    qm = num_q[DivStages];
    if (neg_q[DivStages]) begin
      sat_d = qm > NegLim;
      q_d   = sat_d ? $signed(NegLim[CoordW-1:0]) : $signed(-qm[CoordW-1:0]);
    end else begin
      sat_d = qm > PosLim;
      q_d   = sat_d ? $signed(PosLim[CoordW-1:0]) : $signed(qm[CoordW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q   <= q_d;
      sat_q <= sat_d;
    end
  end

  assign q_o   = q_q;
  assign sat_o = sat_q;

endmodule

### tb/vtpd_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpd_tb_if
// Testbench-side note: channel interfaces come from the RTL; this file holds
// the vertex and result record types used by the bench.
// ----------------------------------------------------------------------------
package vtpd_tb_pkg;
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               div;
    logic               sat;
  } xform_t;
endpackage

### tb/vertex_transform_perspective_divide_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_unit_tb
// Self-checking bench for the vertex transform unit. Directed vertices, then
// random ones under several matrices, most phases with random backpressure on both sides;
// every result is compared against a bit-accurate transform and divide model.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide_unit_tb;
  import vtpd_pkg::*;
  import vtpd_tb_pkg::*;

  localparam int Limit = 400000;
  localparam int DrainCycles = PipeDepth + 8;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [RowIdxW-1:0] cfg_idx_i;
  logic [RowW-1:0] cfg_data_i;

  vtpd_in_if  in_ch ();
  vtpd_out_if out_ch ();

  vertex_transform_perspective_divide_unit dut (
    .clk_i, .rst_ni, .in_i(in_ch), .out_o(out_ch),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  logic [RowW-1:0] rows [NumRows];
  xform_t expected_q [$];
  int errors = 0, cycles = 0, sent = 0, received = 0;
  int src_idle = 0, snk_idle = 0;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] clip(input logic signed [79:0] v,
                                              inout logic sat);
    if (v > 80'sd2147483647) begin
      sat = 1;
      return 32'sh7fffffff;
    end
    if (v < -80'sd2147483648) begin
      sat = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic xform_t transform_vertex(input vertex_t v);
    logic signed [31:0] comp [4];
    logic signed [31:0] t [4];
    logic signed [79:0] acc, num;
    logic signed [15:0] cf;
    logic sat;
    xform_t res;
    comp[0] = v.x; comp[1] = v.y; comp[2] = v.z; comp[3] = v.w;
    sat = 0;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) begin
        cf = rows[r][16*c +: 16];
        acc += 80'(cf) * 80'(comp[c]);
      end
      acc += 80'sd1 <<< (CoeffFracBits - 1);
      t[r] = clip(acc >>> CoeffFracBits, sat);
    end
    res.div = t[3] > 0;
    if (res.div) begin
      for (int r = 0; r < 3; r++) begin
        num = 80'(t[r]) <<< CoordFracBits;
        t[r] = clip(num / 80'(t[3]), sat);
      end
    end
    res.x = t[0]; res.y = t[1]; res.z = t[2]; res.w = t[3]; res.sat = sat;
    return res;
  endfunction

  task automatic write_row(input int idx, input logic [RowW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1; cfg_idx_i = idx[RowIdxW-1:0]; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 0;
    rows[idx] = val;
  endtask

  task automatic load_matrix(input logic [RowW-1:0] r0, r1, r2, r3);
    in_ch.valid = 0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    write_row(0, r0); write_row(1, r1); write_row(2, r2); write_row(3, r3);
  endtask

  // called at a falling edge; leaves valid high so transactions can follow back to back
  task automatic send_vertex(input vertex_t v);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid = 0;
      @(negedge clk_i);
    end
    in_ch.valid = 1;
    in_ch.in_x = v.x; in_ch.in_y = v.y; in_ch.in_z = v.z; in_ch.in_w = v.w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_q.push_back(transform_vertex(v));
    sent++;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i)
    out_ch.ready <= ($urandom_range(99) >= snk_idle);

  always @(posedge clk_i) begin
    xform_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      received++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.out_x !== e.x) begin
          $error("out_x exp %0d got %0d", e.x, out_ch.out_x); errors++;
        end
        if (out_ch.out_y !== e.y) begin
          $error("out_y exp %0d got %0d", e.y, out_ch.out_y); errors++;
        end
        if (out_ch.out_z !== e.z) begin
          $error("out_z exp %0d got %0d", e.z, out_ch.out_z); errors++;
        end
        if (out_ch.out_w !== e.w) begin
          $error("out_w exp %0d got %0d", e.w, out_ch.out_w); errors++;
        end
        if (out_ch.was_divided !== e.div) begin
          $error("was_divided exp %0d got %0d", e.div, out_ch.was_divided); errors++;
        end
        if (out_ch.saturated !== e.sat) begin
          $error("saturated exp %0d got %0d", e.sat, out_ch.saturated); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h80000000;
      2: return 32'h7fffffff;
      default: return $signed($urandom_range(8 << 16)) - (4 << 16);
    endcase
  endfunction

  function automatic logic [RowW-1:0] rand_row();
    logic [RowW-1:0] r;
    for (int c = 0; c < 4; c++)
      r[16*c +: 16] = ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'($signed($urandom_range(8192)) - 4096);
    return r;
  endfunction

  // Directed table: vertex, and whether a typed-in result is checked too.
  typedef struct {
    vertex_t v;
    bit      typed;
    xform_t  res;
  } dir_row_t;

  localparam logic [RowW-1:0] Ident0 = 64'h0000_0000_0000_1000;
  localparam logic [RowW-1:0] Ident1 = 64'h0000_0000_1000_0000;
  localparam logic [RowW-1:0] Ident2 = 64'h0000_1000_0000_0000;
  localparam logic [RowW-1:0] Ident3 = 64'h1000_0000_0000_0000;

  initial begin
    dir_row_t zero_tbl [3];
    vertex_t ident_tbl [10];
    vertex_t v;
    xform_t got;
    cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0;
    in_ch.valid = 0; in_ch.in_x = 0; in_ch.in_y = 0; in_ch.in_z = 0; in_ch.in_w = 0;
    for (int r = 0; r < NumRows; r++) rows[r] = '0;
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // zero matrix after reset: everything reads zero, no divide
    zero_tbl[0] = '{'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000}, 1, '0};
    zero_tbl[1] = '{'{32'sh00010000, 32'sh00010000, 32'sh00010000, 32'sh00010000}, 1, '0};
    zero_tbl[2] = '{'{32'sh0, 32'sh0, 32'sh0, 32'sh0}, 1, '0};
    foreach (zero_tbl[i]) begin
      got = transform_vertex(zero_tbl[i].v);
      if (zero_tbl[i].typed && got !== zero_tbl[i].res) begin
        $error("zero-matrix prediction mismatch row %0d", i); errors++;
      end
      send_vertex(zero_tbl[i].v);
    end

    load_matrix(Ident0, Ident1, Ident2, Ident3);
    ident_tbl[0] = '{32'sh00020000, 32'sh00030000, 32'sh00040000, 32'sh00010000};
    ident_tbl[1] = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh00000001};
    ident_tbl[2] = '{32'sh00010000, 32'sh00010000, 32'sh00010000, 32'sh00000000};
    ident_tbl[3] = '{32'sh00010000, -32'sh00010000, 32'sh00010000, -32'sh00020000};
    ident_tbl[4] = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
    ident_tbl[5] = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    ident_tbl[6] = '{-32'sh00030000, 32'sh00005000, 32'sh00000001, 32'sh00020000};
    ident_tbl[7] = '{32'sh80000000, 32'sh7fffffff, 32'sh0, 32'sh00000001};
    ident_tbl[8] = '{-32'sh1, 32'sh1, -32'sh1, 32'sh7fffffff};
    ident_tbl[9] = '{32'sh1, 32'sh1, 32'sh1, 32'sh1};
    foreach (ident_tbl[i]) send_vertex(ident_tbl[i]);

    // extreme coefficients: sum saturation and rounding halves
    load_matrix(64'h7fff_7fff_7fff_7fff, 64'h8000_8000_8000_8000,
                64'h0001_8001_ffff_0001, 64'h8000_7fff_0001_ffff);
    send_vertex('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    send_vertex('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000});
    send_vertex('{32'sh00000800, 32'sh00000800, 32'sh00000800, 32'sh00000800});
    send_vertex('{32'shfffff800, 32'sh0, 32'sh0, 32'sh0});
    send_vertex('{32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff});

    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin src_idle = 28; snk_idle = 49; end
        1: begin src_idle = 49; snk_idle = 28; end
        default: begin src_idle = 0; snk_idle = 0; end
      endcase
      if (phase == 3)
        load_matrix(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                    64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      else if (phase == 5)
        load_matrix(Ident0, Ident1, Ident2, Ident3 | 64'h0000_0000_0000_0100);
      else
        load_matrix(rand_row(), rand_row(), rand_row(),
                    ($urandom_range(1) ? Ident3 : rand_row()));
      for (int n = 0; n < 85; n++) begin
        v.x = rand_coord(); v.y = rand_coord(); v.z = rand_coord();
        v.w = ($urandom_range(3) == 0) ? rand_coord()
                                       : 32'($urandom_range(4 << 16, 1));
        send_vertex(v);
      end
    end

    in_ch.valid = 0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    $display("Sent %0d vertices over nine matrix settings, received %0d results.",
             sent, received);
    $display("Covered zero, identity, extreme and random matrices under backpressure.");
    if (errors == 0 && expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

### files.f
hw/rtl/vtpd_pkg.sv
hw/rtl/vtpd_in_if.sv
hw/rtl/vtpd_out_if.sv
hw/rtl/vtpd_div.sv
hw/rtl/vertex_transform_perspective_divide_unit.sv
tb/vtpd_tb_if.sv
tb/vertex_transform_perspective_divide_unit_tb.sv
